FILE: src/plr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plr_pkg
// Shared types and widths for the permutation rank cell chain.
// ----------------------------------------------------------------------------
package plr_pkg;

  // image values arrive as 4-bit numbers
  localparam int unsigned VALUE_W = 4;
  // position and count widths cover every degree that 4-bit values allow (up to 15)
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned RANK_W  = 16;

  // one permutation element travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               err;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
  } token_t;

endpackage : plr_pkg
`default_nettype wire

FILE: src/plr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plr_cell
// One cell of the chain: owns the seen bit of value INDEX and counts it for
// every passing element with a smaller value.
// ----------------------------------------------------------------------------
module plr_cell #(
  parameter int unsigned INDEX = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire plr_pkg::token_t tok_i,
  output plr_pkg::token_t      tok_o
);

  logic            seen_q, seen_d;
  plr_pkg::token_t tok_q, tok_d;
  logic            hit;
  logic            above;
  logic            seen_now;
  logic            want;

  always_comb begin
    hit      = (int'(tok_i.value) == int'(INDEX));
    above    = (int'(tok_i.value) <  int'(INDEX));
    seen_now = seen_q | hit;
    // on the last element, values 1..pos must be present and no others
    want     = (int'(INDEX) <= int'(tok_i.pos));

    tok_d = tok_i;
    if (seen_q && above) begin
      tok_d.count = tok_i.count + plr_pkg::CNT_W'(1);
    end
    if (seen_q && hit) begin
      tok_d.err = 1'b1;
    end
    if (tok_i.last && (seen_now != want)) begin
      tok_d.err = 1'b1;
    end

    seen_d = seen_q;
    if (tok_i.valid) begin
      // the last element clears the cell for the next permutation
      seen_d = tok_i.last ? 1'b0 : seen_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      tok_q  <= '0;
    end else if (adv_i) begin
      seen_q <= seen_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule : plr_cell
`default_nettype wire

FILE: src/plr_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plr_accum
// Tail of the chain: accumulates count * (x-1)!, the inversion parity and the
// error flag, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module plr_accum (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire plr_pkg::token_t             tok_i,
  output logic                             hold_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [plr_pkg::RANK_W-1:0]       rank_o,
  output logic                             is_even_o,
  output logic                             invalid_o
);

  localparam int unsigned PROD_W = plr_pkg::RANK_W + plr_pkg::CNT_W;

  logic [plr_pkg::RANK_W-1:0] rank_q, rank_d;
  logic [plr_pkg::RANK_W-1:0] fact_q, fact_d;
  logic                       parity_q, parity_d;
  logic                       err_q, err_d;
  logic                       out_valid_q, out_valid_d;
  logic [plr_pkg::RANK_W-1:0] out_rank_q, out_rank_d;
  logic                       out_even_q, out_even_d;
  logic                       out_inv_q, out_inv_d;
  logic [PROD_W-1:0]          term;
  logic [PROD_W-1:0]          fact_next;
  logic                       adv;
  logic                       bad;

  always_comb begin
    // a finished result may wait while non-final elements keep flowing
    hold_o = out_valid_q && !out_ready_i && tok_i.valid && tok_i.last;
    adv    = !hold_o;

    term      = PROD_W'(tok_i.count) * PROD_W'(fact_q);
    fact_next = PROD_W'(fact_q) * PROD_W'(tok_i.pos);

    rank_d   = rank_q + term[plr_pkg::RANK_W-1:0];
    fact_d   = fact_next[plr_pkg::RANK_W-1:0];
    parity_d = parity_q ^ tok_i.count[0];
    err_d    = err_q | tok_i.err;
    bad      = err_d;

    out_valid_d = out_valid_q && !out_ready_i;
    out_rank_d  = out_rank_q;
    out_even_d  = out_even_q;
    out_inv_d   = out_inv_q;
    if (adv && tok_i.valid && tok_i.last) begin
      out_valid_d = 1'b1;
      out_rank_d  = bad ? '0 : rank_d;
      out_even_d  = bad ? 1'b0 : ~parity_d;
      out_inv_d   = bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q   <= '0;
      fact_q   <= plr_pkg::RANK_W'(1);
      parity_q <= 1'b0;
      err_q    <= 1'b0;
    end else if (adv && tok_i.valid) begin
      if (tok_i.last) begin
        rank_q   <= '0;
        fact_q   <= plr_pkg::RANK_W'(1);
        parity_q <= 1'b0;
        err_q    <= 1'b0;
      end else begin
        rank_q   <= rank_d;
        fact_q   <= fact_d;
        parity_q <= parity_d;
        err_q    <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rank_q <= out_rank_d;
    out_even_q <= out_even_d;
    out_inv_q  <= out_inv_d;
  end

  assign out_valid_o = out_valid_q;
  assign rank_o      = out_rank_q;
  assign is_even_o   = out_even_q;
  assign invalid_o   = out_inv_q;

endmodule : plr_accum
`default_nettype wire

FILE: src/permutation_lehmer_rank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// permutation_lehmer_rank
// Modified Lehmer rank of a permutation streamed one image per transaction.
// ----------------------------------------------------------------------------
// Takes p(1)..p(d), one image per input transaction, the final one marked by
// last_i, and returns one result per permutation: the rank (sum of the count
// of earlier larger images times (x-1)!, modulo 2^16), an even-parity flag and
// an invalid flag. One image is accepted every cycle unless the chain is stopped.
// Each image walks a chain of MAX_DEGREE cells, one per value, and then the
// accumulator, which holds the finished result in its output register. The chain
// stops only while a result waits in the output register and the next
// permutation's last image reaches the accumulator.
module permutation_lehmer_rank #(
  parameter int unsigned MAX_DEGREE = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [plr_pkg::VALUE_W-1:0]  image_value_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [plr_pkg::RANK_W-1:0]        rank_o,
  output logic                              is_even_o,
  output logic                              invalid_o
);

  plr_pkg::token_t            chain [MAX_DEGREE+1];
  logic [plr_pkg::POS_W-1:0]  pos_q, pos_d;
  logic                       hold;
  logic                       adv;

  assign adv        = !hold;
  assign in_ready_o = adv;

  // position counter saturates one past the maximum degree
  always_comb begin
    pos_d = pos_q;
    if (pos_q <= plr_pkg::POS_W'(MAX_DEGREE)) begin
      pos_d = pos_q + plr_pkg::POS_W'(1);
    end

    chain[0].valid = in_valid_i;
    chain[0].last  = last_i;
    chain[0].value = image_value_i;
    chain[0].pos   = pos_d;
    chain[0].count = '0;
    chain[0].err   = (pos_d > plr_pkg::POS_W'(MAX_DEGREE)) ||
                     (image_value_i == '0) ||
                     (int'(image_value_i) > int'(MAX_DEGREE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      pos_q <= last_i ? '0 : pos_d;
    end
  end

  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
    plr_cell #(
      .INDEX (k + 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  plr_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (chain[MAX_DEGREE]),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rank_o      (rank_o),
    .is_even_o   (is_even_o),
    .invalid_o   (invalid_o)
  );

endmodule : permutation_lehmer_rank
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the permutation rank block.
// ----------------------------------------------------------------------------
// A short directed table covers single-item permutations, out-of-range and
// repeated images, a gap in the value set, the identity and the reverse of
// degree eight. The random part that follows is mostly well-formed
// permutations of random degree and order. The rest are broken sets: repeats,
// out-of-range images, gaps and too many images. Every result is compared with
// an in-bench rank model or with the value typed into the table. Both
// handshakes get random gaps.
module tb_top;

  localparam int unsigned MAX_DEGREE = 8;
  localparam int unsigned NUM_ITEMS  = 400;

  typedef struct packed {
    logic [plr_pkg::RANK_W-1:0] rank;
    logic                       is_even;
    logic                       invalid;
  } rank_result_t;

  typedef struct {
    logic [plr_pkg::VALUE_W-1:0] value;
    logic                        last;
    logic                        known;
    rank_result_t                exp;
  } stim_row_t;

  typedef int unsigned val_q_t[$];

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [plr_pkg::VALUE_W-1:0] image_value_i;
  logic                        last_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [plr_pkg::RANK_W-1:0]  rank_o;
  logic                        is_even_o;
  logic                        invalid_o;

  // side data that travels with the current input transaction
  logic                        row_known;
  rank_result_t                row_exp;

  // rank model state
  logic [MAX_DEGREE-1:0]       seen_mask;
  logic [3:0]                  pos_cnt;
  logic [15:0]                 fact_acc;
  logic [15:0]                 rank_acc;
  logic                        parity_acc;
  logic                        err_flag;

  rank_result_t                pending_ranks[$];
  stim_row_t                   stim_rows[$];
  int unsigned                 fail_count;
  bit                          no_idle;

  permutation_lehmer_rank #(
    .MAX_DEGREE(MAX_DEGREE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .image_value_i(image_value_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rank_o       (rank_o),
    .is_even_o    (is_even_o),
    .invalid_o    (invalid_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("permutation_lehmer_rank test failed");
    $finish;
  end

  task automatic clear_rank_state();
    seen_mask  = '0;
    pos_cnt    = '0;
    fact_acc   = 16'd1;
    rank_acc   = '0;
    parity_acc = 1'b0;
    err_flag   = 1'b0;
  endtask

  // one image into the rank model; emits is set on the last image
  task automatic lehmer_step(input logic [3:0] v, input logic l,
                             output logic emits, output rank_result_t res);
    int unsigned larger;
    int unsigned x;
    int unsigned full;
    logic        bad;
    larger = 0;
    emits  = 1'b0;
    res    = '0;
    if (pos_cnt <= MAX_DEGREE) pos_cnt = pos_cnt + 4'd1;
    x = pos_cnt;
    if (!err_flag) begin
      if (x > MAX_DEGREE || v == 0 || v > MAX_DEGREE) begin
        err_flag = 1'b1;
      end else if (seen_mask[v-1]) begin
        err_flag = 1'b1;
      end else begin
        // earlier images larger than v
        for (int unsigned i = v; i < MAX_DEGREE; i++) larger += seen_mask[i];
        rank_acc      = rank_acc + 16'(larger * fact_acc);
        parity_acc    = parity_acc ^ larger[0];
        fact_acc      = 16'(fact_acc * x);
        seen_mask[v-1] = 1'b1;
      end
    end
    if (l) begin
      full = (1 << x) - 1;
      bad  = err_flag || (int'(seen_mask) != full);
      res.rank    = bad ? '0 : rank_acc;
      res.is_even = bad ? 1'b0 : ~parity_acc;
      res.invalid = bad;
      emits = 1'b1;
      clear_rank_state();
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic val_q_t shuffled(int unsigned n);
    val_q_t      q;
    int unsigned j;
    int unsigned t;
    for (int unsigned i = 1; i <= n; i++) q.insert(q.size(), i);
    for (int i = int'(n) - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  task automatic add_row(input logic [3:0] v, input logic l, input logic known,
                         input logic [15:0] r, input logic e, input logic inv);
    stim_row_t row;
    row.value       = v;
    row.last        = l;
    row.known       = known;
    row.exp.rank    = r;
    row.exp.is_even = e;
    row.exp.invalid = inv;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic send_image(input stim_row_t row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    image_value_i <= row.value;
    last_i        <= row.last;
    row_known     <= row.known;
    row_exp       <= row.exp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_perm(input val_q_t vals);
    stim_row_t row;
    row.known = 1'b0;
    row.exp   = '0;
    for (int i = 0; i < vals.size(); i++) begin
      row.value = 4'(vals[i]);
      row.last  = (i == vals.size() - 1);
      send_image(row);
    end
  endtask

  // receiver stalls
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  // input transactions feed the model first, then output transactions are checked
  always @(posedge clk_i) begin
    logic         emits;
    rank_result_t res;
    rank_result_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      lehmer_step(image_value_i, last_i, emits, res);
      if (emits) pending_ranks.insert(pending_ranks.size(), row_known ? row_exp : res);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ranks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: rank=%0d is_even=%0b invalid=%0b",
                   rank_o, is_even_o, invalid_o);
      end else begin
        want = pending_ranks.pop_front();
        if (rank_o !== want.rank || is_even_o !== want.is_even ||
            invalid_o !== want.invalid) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: rank exp=%0d got=%0d, is_even exp=%0b got=%0b, ",
                      "invalid exp=%0b got=%0b"},
                     want.rank, rank_o, want.is_even, is_even_o, want.invalid, invalid_o);
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned kind;
    int unsigned d;
    int unsigned i;
    int unsigned j;
    val_q_t      perm;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    image_value_i = '0;
    last_i        = 1'b0;
    row_known     = 1'b0;
    row_exp       = '0;
    fail_count    = 0;
    no_idle       = 1'b0;
    clear_rank_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single images: valid, zero, all ones, above the degree limit, a gap
    add_row(4'd1,  1'b1, 1'b1, 16'd0, 1'b1, 1'b0);
    add_row(4'd0,  1'b1, 1'b1, 16'd0, 1'b0, 1'b1);
    add_row(4'd15, 1'b1, 1'b1, 16'd0, 1'b0, 1'b1);
    add_row(4'd9,  1'b1, 1'b1, 16'd0, 1'b0, 1'b1);
    add_row(4'd2,  1'b1, 1'b1, 16'd0, 1'b0, 1'b1);
    // identity of full degree
    for (int unsigned k = 1; k <= MAX_DEGREE; k++)
      add_row(4'(k), k == MAX_DEGREE, k == MAX_DEGREE, 16'd0, 1'b1, 1'b0);
    // reverse of full degree: largest rank, 28 inversions
    for (int unsigned k = MAX_DEGREE; k >= 1; k--)
      add_row(4'(k), k == 1, k == 1, 16'd40319, 1'b1, 1'b0);
    // repeated image
    add_row(4'd1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0);
    add_row(4'd1, 1'b1, 1'b1, 16'd0, 1'b0, 1'b1);

    foreach (stim_rows[k]) send_image(stim_rows[k]);

    sent = 0;
    while (sent < NUM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 75) begin
        perm = shuffled($urandom_range(1, MAX_DEGREE));
      end else if (kind < 82) begin
        d    = $urandom_range(2, MAX_DEGREE);
        perm = shuffled(d);
        i    = $urandom_range(0, d - 1);
        j    = (i + 1 + $urandom_range(0, d - 2)) % d;
        perm[i] = perm[j];
      end else if (kind < 88) begin
        d    = $urandom_range(1, MAX_DEGREE);
        perm = shuffled(d);
        perm[$urandom_range(0, d - 1)] = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
      end else if (kind < 94) begin
        // distinct values that need not be 1..d
        perm = shuffled(MAX_DEGREE);
        d    = $urandom_range(1, MAX_DEGREE - 1);
        while (perm.size() > d) perm.delete(perm.size() - 1);
      end else begin
        perm = shuffled(MAX_DEGREE);
        repeat ($urandom_range(1, 4)) perm.insert(perm.size(), $urandom_range(0, 15));
      end
      send_perm(perm);
      sent += perm.size();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (4 * (MAX_DEGREE + 1)) @(posedge clk_i);
    fail_count += pending_ranks.size();

    if (fail_count == 0) begin
      $display("permutation_lehmer_rank test passed");
    end else begin
      $display("permutation_lehmer_rank test failed");
    end
    $finish;
  end

endmodule
